// File: design/banked_memory_mapper_top_macros.svh
// Assertion macros for the banked memory mapper.
`ifndef BANKED_MEMORY_MAPPER_TOP_MACROS_SVH
`define BANKED_MEMORY_MAPPER_TOP_MACROS_SVH

// Checked at every clock edge while out of reset.
`define BMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define BMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/bmm_pkg.sv
// Types and constants shared by the banked memory mapper modules.
package bmm_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned OffsetW = 18;

  localparam logic [7:0] PortMode  = 8'hfd;
  localparam logic [7:0] PortPages = 8'hfe;

  localparam logic       FuncMem  = 1'b0;
  localparam logic       FuncPort = 1'b1;

  localparam logic [3:0] RamPageCommon = 4'hf;
  localparam logic [2:0] RomPageNone   = 3'd7;

  typedef enum logic [1:0] {
    MODE_BOOT   = 2'd0,
    MODE_RAM    = 2'd1,
    MODE_BASIC  = 2'd2,
    MODE_EXTRAM = 2'd3
  } map_mode_e;

  typedef enum logic [2:0] {
    TGT_NONE   = 3'd0,
    TGT_BOOT   = 3'd1,
    TGT_BASIC  = 3'd2,
    TGT_EXT    = 3'd3,
    TGT_RAM    = 3'd4,
    TGT_COMMON = 3'd5
  } target_e;

  typedef struct packed {
    logic             func;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
  } bmm_req_t;

  typedef struct packed {
    target_e            target;
    logic [OffsetW-1:0] offset;
    logic               writable;
  } bmm_rsp_t;

  typedef struct packed {
    map_mode_e  map_mode;
    logic [2:0] rom_page;
    logic [3:0] ram_page;
  } bmm_cfg_t;

endpackage

// File: design/bmm_translate.sv
// Address decode: memory address plus bank registers to target, offset, writable.
module bmm_translate (
  input  logic [bmm_pkg::AddrW-1:0] address_i,
  input  bmm_pkg::bmm_cfg_t         cfg_i,
  output bmm_pkg::bmm_rsp_t         rsp_o
);
  import bmm_pkg::*;

  logic [12:0] rel_rom;
  logic [13:0] rel_up;
  logic [2:0]  rp;
  logic [3:0]  pp;

  assign rel_rom = address_i[12:0];
  assign rel_up  = address_i[13:0];
  assign rp      = cfg_i.rom_page;
  assign pp      = cfg_i.ram_page;

  always_comb begin
    rsp_o = '{target: TGT_NONE, offset: '0, writable: 1'b0};
    if (cfg_i.map_mode == MODE_RAM) begin
      if (address_i[15:11] == 5'h1f) begin
        rsp_o = '{TGT_COMMON, OffsetW'(address_i[10:0]), 1'b1};
      end else begin
        rsp_o = '{TGT_RAM, OffsetW'(address_i), 1'b1};
      end
    end else if (address_i[15:14] == 2'b01 || address_i[15:14] == 2'b10) begin
      rsp_o = '{TGT_RAM, OffsetW'(address_i), 1'b1};
    end else if (address_i[15:14] == 2'b11) begin
      // upper 16K window, selected by ram page
      if (pp == RamPageCommon) begin
        if (address_i[15:11] == 5'h1f) begin
          rsp_o = '{TGT_COMMON, OffsetW'(address_i[10:0]), 1'b1};
        end
      end else if (cfg_i.map_mode == MODE_EXTRAM) begin
        // bank p at 0x10000 + p*0x4000, i.e. 16K bank number p+4
        if (pp <= 4'd11) begin
          rsp_o = '{TGT_RAM, {pp + 4'd4, rel_up}, 1'b1};
        end
      end else if (pp == 4'd0) begin
        rsp_o = '{TGT_RAM, OffsetW'(address_i), 1'b1};
      end else if (pp == 4'd1) begin
        rsp_o = '{TGT_RAM, OffsetW'(rel_up), 1'b1};
      end else if (cfg_i.map_mode == MODE_BASIC && pp <= 4'd13) begin
        rsp_o = '{TGT_RAM, {pp + 4'd2, rel_up}, 1'b1};
      end
    end else if (cfg_i.map_mode == MODE_BOOT) begin
      if (!address_i[13]) begin
        rsp_o = '{TGT_BOOT, OffsetW'({1'b1, address_i[11:0]}), 1'b0};
      end else begin
        rsp_o = '{TGT_BASIC, OffsetW'(address_i), 1'b0};
      end
    end else if (!address_i[13]) begin
      if (cfg_i.map_mode == MODE_BASIC) begin
        rsp_o = '{TGT_BASIC, OffsetW'(address_i), 1'b0};
      end else begin
        rsp_o = '{TGT_RAM, OffsetW'(address_i), 1'b1};
      end
    end else begin
      // 0x2000 window, selected by rom page
      if (rp >= 3'd3 && rp <= 3'd6) begin
        rsp_o = '{TGT_EXT, OffsetW'({2'(rp - 3'd3), rel_rom}), 1'b0};
      end else if (rp == RomPageNone) begin
        rsp_o = '{target: TGT_NONE, offset: '0, writable: 1'b0};
      end else if (cfg_i.map_mode == MODE_BASIC) begin
        rsp_o = '{TGT_BASIC, OffsetW'({rp + 3'd1, rel_rom}), 1'b0};
      end else if (rp == 3'd0) begin
        rsp_o = '{TGT_RAM, OffsetW'(address_i), 1'b1};
      end else if (rp == 3'd1) begin
        rsp_o = '{TGT_RAM, OffsetW'({3'b110, rel_rom}), 1'b1};
      end else begin
        rsp_o = '{TGT_RAM, OffsetW'({3'b111, rel_rom}), 1'b1};
      end
    end
  end

endmodule

// File: design/banked_memory_mapper_top.sv
// Top level of the banked memory mapper: input stage, bank registers, result register.
`include "banked_memory_mapper_top_macros.svh"

// Banked memory mapper. Each item on the input channel is either a memory
// access (func 0), which yields one result item with the target memory,
// the byte offset inside it and a writable flag, or a port write (func 1),
// which yields no result: port 0xfd loads the map mode from data[1:0], port
// 0xfe loads the ROM page from data[2:0] and the RAM page from data[7:4];
// other ports are ignored. Items pass through two registers: an input stage,
// where the address is decoded against the bank registers and port writes
// take effect, and a result register. A new item is accepted every cycle while
// the input is ready; a memory access moves from the input stage into the
// result register once that register is free.
// The input stays ready while a result waits, as long as the input stage can
// move on (it is empty, holds a port write, or the result register frees up).
// Port writes are applied in order, so an access right after a port write
// already sees the new mapping. All bank registers reset to 0 (mode 0).
module banked_memory_mapper_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmm_pkg::bmm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmm_pkg::bmm_rsp_t out_rsp_o
);
  import bmm_pkg::*;

  // input stage
  logic     s1_valid_q;
  bmm_req_t s1_q;
  logic     s1_adv;
  logic     s1_is_port;

  // bank registers
  bmm_cfg_t cfg_q, cfg_d;

  // result register
  logic     out_valid_q, out_valid_d;
  bmm_rsp_t out_q;
  bmm_rsp_t xlat_rsp;
  logic     out_free;

  assign s1_is_port = s1_q.func == FuncPort;
  assign out_free   = !out_valid_q || out_ready_i;
  // a port write leaves without touching the result register
  assign s1_adv     = s1_valid_q && (s1_is_port || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  bmm_translate u_xlat (
    .address_i (s1_q.address),
    .cfg_i     (cfg_q),
    .rsp_o     (xlat_rsp)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (s1_adv && s1_is_port) begin
      case (s1_q.address[7:0])
        PortMode: begin
          cfg_d.map_mode = map_mode_e'(s1_q.data[1:0]);
        end
        PortPages: begin
          cfg_d.rom_page = s1_q.data[2:0];
          cfg_d.ram_page = s1_q.data[7:4];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (s1_adv && !s1_is_port) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= '{map_mode: MODE_BOOT, rom_page: '0, ram_page: '0};
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_q <= in_req_i;
    end
    if (s1_adv && !s1_is_port) begin
      out_q <= xlat_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // the input only stalls when both stages hold a blocked memory access
  `BMM_ASSERT(a_stall_cause, !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i && !s1_is_port), "input stalled without a blocked access")
  // unmapped windows carry a zero offset and drop writes
  `BMM_ASSERT(a_unmapped_clean, (out_valid_o && out_rsp_o.target == TGT_NONE) |-> (out_rsp_o.offset == '0 && !out_rsp_o.writable), "unmapped result not clean")
  // ROM targets are never writable
  `BMM_ASSERT(a_rom_readonly, (out_valid_o && (out_rsp_o.target == TGT_BOOT || out_rsp_o.target == TGT_BASIC || out_rsp_o.target == TGT_EXT)) |-> !out_rsp_o.writable, "ROM result marked writable")
  // map mode only moves after a write to the mode port
  `BMM_ASSERT(a_mode_source, !$stable(cfg_q.map_mode) |-> $past(s1_adv && s1_is_port && s1_q.address[7:0] == PortMode), "map mode changed without a port write")
  // nothing is presented during reset (the first edge may still see an unset flop)
  `BMM_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (out_valid_o !== 1'b1), "result valid during reset")

endmodule
